// File: rtl/zsda_pkg.sv
// ----------------------------------------------------------------------------
// zsda_pkg
// Types, constants and the CRC byte step shared by the alternate-byte
// ZIP stream decrypt block.
// ----------------------------------------------------------------------------
package zsda_pkg;

    localparam logic [31:0] INIT_KEY_A = 32'h1234_5678;
    localparam logic [31:0] INIT_KEY_B = 32'h2345_6789;
    localparam logic [31:0] INIT_KEY_C = 32'h3456_7890;
    localparam logic [31:0] KEY_B_MULT = 32'd134775813;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

    typedef enum logic [1:0] {
        OP_RESTART = 2'd0,
        OP_ABSORB  = 2'd1,
        OP_DECRYPT = 2'd2,
        OP_UNUSED  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STREAM,
        ST_CRC_A,
        ST_MULT,
        ST_CRC_C,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic restart;
        logic ks_step;
        logic crc_a_step;
        logic use_stream;
        logic mult_step;
        logic crc_c_step;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic odd_position;
        logic out_free;
    } dp_status_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int n = 0; n < 8; n++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

// File: rtl/zsda_datapath.sv
// ----------------------------------------------------------------------------
// zsda_datapath
// Key registers, keystream multiply, CRC steps, key_b multiply and the
// output register.
// ----------------------------------------------------------------------------
module zsda_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  zsda_pkg::dp_cmd_t    cmd,
    output zsda_pkg::dp_status_t status,
    input  logic [7:0]           in_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte
);

    logic [31:0] key_a_reg, key_a_next;
    logic [31:0] key_b_reg, key_b_next;
    logic [31:0] key_c_reg, key_c_next;
    logic        odd_reg, odd_next;
    logic [7:0]  data_reg, data_next;
    logic [7:0]  ks_reg, ks_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;

    logic [15:0] ks_t;
    logic [31:0] ks_prod;
    logic [7:0]  src_byte;
    logic [31:0] b_sum;

    always_comb begin
        ks_t     = key_c_reg[15:0] | 16'h0002;
        ks_prod  = {16'd0, ks_t} * {16'd0, ks_t ^ 16'h0001};
        src_byte = cmd.use_stream ? (data_reg ^ ks_reg) : data_reg;
        b_sum    = key_b_reg + {24'd0, key_a_reg[7:0]};

        key_a_next     = key_a_reg;
        key_b_next     = key_b_reg;
        key_c_next     = key_c_reg;
        odd_next       = odd_reg;
        data_next      = data_reg;
        ks_next        = ks_reg;
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.restart) begin
            key_a_next = zsda_pkg::INIT_KEY_A;
            key_b_next = zsda_pkg::INIT_KEY_B;
            key_c_next = zsda_pkg::INIT_KEY_C;
            odd_next   = 1'b0;
        end
        if (cmd.load_in) begin
            data_next = in_byte;
        end
        if (cmd.ks_step) begin
            ks_next = ks_prod[15:8];
        end
        if (cmd.crc_a_step) begin
            key_a_next = zsda_pkg::crc_byte(key_a_reg, src_byte);
            data_next  = src_byte;
        end
        if (cmd.mult_step) begin
            key_b_next = b_sum * zsda_pkg::KEY_B_MULT + 32'd1;
        end
        if (cmd.crc_c_step) begin
            key_c_next = zsda_pkg::crc_byte(key_c_reg, key_b_reg[31:24]);
        end
        if (cmd.emit) begin
            out_byte_next  = data_reg;
            out_valid_next = 1'b1;
            odd_next       = !odd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_a_reg     <= zsda_pkg::INIT_KEY_A;
            key_b_reg     <= zsda_pkg::INIT_KEY_B;
            key_c_reg     <= zsda_pkg::INIT_KEY_C;
            odd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            key_a_reg     <= key_a_next;
            key_b_reg     <= key_b_next;
            key_c_reg     <= key_c_next;
            odd_reg       <= odd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg     <= data_next;
        ks_reg       <= ks_next;
        out_byte_reg <= out_byte_next;
    end

    assign status.odd_position = odd_reg;
    assign status.out_free     = !out_valid_reg || out_ready;
    assign out_valid           = out_valid_reg;
    assign out_byte            = out_byte_reg;

endmodule

// File: rtl/zsda_ctrl.sv
// ----------------------------------------------------------------------------
// zsda_ctrl
// Sequencer: decodes the opcode of an accepted request and steps the
// datapath through keystream, key update and output.
// ----------------------------------------------------------------------------
module zsda_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_opcode,
    input  zsda_pkg::dp_status_t status,
    output zsda_pkg::dp_cmd_t    cmd
);

    zsda_pkg::state_t state_reg, state_next;
    logic             is_data_reg, is_data_next;
    zsda_pkg::opcode_t op;

    assign op = zsda_pkg::opcode_t'(in_opcode);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= zsda_pkg::ST_IDLE;
            is_data_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            is_data_reg <= is_data_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        is_data_next = is_data_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            zsda_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    unique case (op)
                        zsda_pkg::OP_RESTART: begin
                            cmd.restart = 1'b1;
                        end
                        zsda_pkg::OP_ABSORB: begin
                            cmd.load_in  = 1'b1;
                            is_data_next = 1'b0;
                            state_next   = zsda_pkg::ST_CRC_A;
                        end
                        zsda_pkg::OP_DECRYPT: begin
                            cmd.load_in  = 1'b1;
                            is_data_next = 1'b1;
                            state_next   = status.odd_position ? zsda_pkg::ST_EMIT
                                                               : zsda_pkg::ST_STREAM;
                        end
                        zsda_pkg::OP_UNUSED: begin
                        end
                    endcase
                end
            end
            zsda_pkg::ST_STREAM: begin
                cmd.ks_step = 1'b1;
                state_next  = zsda_pkg::ST_CRC_A;
            end
            zsda_pkg::ST_CRC_A: begin
                cmd.crc_a_step = 1'b1;
                cmd.use_stream = is_data_reg;
                state_next     = zsda_pkg::ST_MULT;
            end
            zsda_pkg::ST_MULT: begin
                cmd.mult_step = 1'b1;
                state_next    = zsda_pkg::ST_CRC_C;
            end
            zsda_pkg::ST_CRC_C: begin
                if (!is_data_reg || status.out_free) begin
                    cmd.crc_c_step = 1'b1;
                    cmd.emit       = is_data_reg;
                    state_next     = zsda_pkg::ST_IDLE;
                end
            end
            zsda_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = zsda_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = zsda_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/zip_stream_decrypt_alternate_top.sv
// ----------------------------------------------------------------------------
// zip_stream_decrypt_alternate_top
// Traditional ZIP stream cipher, decrypting every other data byte.
// Steps: restart acts on acceptance; password byte: CRC of key_a, key_b
// multiply, CRC of key_c; odd-position data byte passes to the output;
// even-position data byte: keystream multiply, CRC of key_a, key_b multiply,
// CRC of key_c with the result registered onto m_. One request at a time.
// Reset: keys load their initial values, parity clears, output empties.
// ----------------------------------------------------------------------------
module zip_stream_decrypt_alternate_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0] s_tuser,   // [1:0] opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] out_byte
);

    zsda_pkg::dp_cmd_t    cmd;
    zsda_pkg::dp_status_t status;

    zsda_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tuser),
        .status    (status),
        .cmd       (cmd)
    );

    zsda_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_byte   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata)
    );

endmodule

// File: rtl/zsda_checker.sv
// ----------------------------------------------------------------------------
// zsda_checker
// Port-level checks for the alternate-byte ZIP stream decrypt block.
// ----------------------------------------------------------------------------
module zsda_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_no_result_from_control: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && !m_tvalid && (s_tuser != zsda_pkg::OP_DECRYPT) |=> !m_tvalid)
        else $error("result without data request");

    a_absorb_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_tuser == zsda_pkg::OP_ABSORB) |=> !s_tready)
        else $error("password request not serialized");

    a_restart_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_tuser == zsda_pkg::OP_RESTART) |=> s_tready)
        else $error("restart not single cycle");

endmodule

bind zip_stream_decrypt_alternate_top zsda_checker u_zsda_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the alternate-byte ZIP stream decrypt block. A
// queue-fed driver offers restart, password, data and unused-opcode requests
// on s_, with random gaps. A monitor on m_ checks every result against a
// cycle-free model of the three-key cipher that is updated on each accepted
// request. The run covers a directed opening, random sessions, a long output
// stall, a full drain pause and a gap-free tail.
// ----------------------------------------------------------------------------
module tb_top;
    import zsda_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int RAND_ITEMS = 900;
    localparam int LONG_HOLD  = 300;

    typedef struct packed {
        opcode_t    op;
        logic [7:0] dat;
    } req_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;    // [7:0] data_byte
    logic [1:0] s_tuser  = 2'd0;    // [1:0] opcode
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte

    req_t       pend_q[$];
    logic [7:0] plain_q[$];

    logic [31:0] ka = INIT_KEY_A;
    logic [31:0] kb = INIT_KEY_B;
    logic [31:0] kc = INIT_KEY_C;
    logic        odd_pos = 1'b0;

    logic req_taken = 1'b0;
    logic idle_on   = 1'b1;
    int   tx_gap    = 0;
    int   rx_gap    = 0;
    int   rx_hold_req = 0;
    int   idle_cycles = 0;
    int   err_cnt   = 0;
    int   item_cnt  = 0;

    zip_stream_decrypt_alternate_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // cipher model
    // ------------------------------------------------------------------
    function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (r[0]) begin
                r = (r >> 1) ^ 32'hEDB8_8320;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    task automatic fold_key_byte(input logic [7:0] b);
        ka = crc_fold(ka, b);
        kb = (kb + {24'd0, ka[7:0]}) * KEY_B_MULT + 32'd1;
        kc = crc_fold(kc, kb[31:24]);
    endtask

    task automatic decrypt_predict(input opcode_t op, input logic [7:0] b);
        logic [31:0] t;
        logic [7:0]  pt;
        case (op)
            OP_RESTART: begin
                ka = INIT_KEY_A;
                kb = INIT_KEY_B;
                kc = INIT_KEY_C;
                odd_pos = 1'b0;
            end
            OP_ABSORB: begin
                fold_key_byte(b);
            end
            OP_DECRYPT: begin
                if (!odd_pos) begin
                    t  = {16'd0, kc[15:0] | 16'd2};
                    t  = t * (t ^ 32'd1);
                    pt = b ^ t[15:8];
                    fold_key_byte(pt);
                end else begin
                    pt = b;
                end
                odd_pos = ~odd_pos;
                plain_q.push_back(pt);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else if (!s_tvalid || req_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                tx_gap = $urandom_range(1, 11) - 1;
                s_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                nxt = pend_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.op;
                s_tdata  <= nxt.dat;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result receiver backpressure
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (rx_hold_req > 0) begin
                rx_gap = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                rx_gap = $urandom_range(1, 11) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor, predictor and watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [7:0] want;
        if (!aresetn) begin
            req_taken <= 1'b0;
            ka = INIT_KEY_A;
            kb = INIT_KEY_B;
            kc = INIT_KEY_C;
            odd_pos = 1'b0;
        end else begin
            req_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (plain_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("ERROR: unexpected result out_byte=%02h", m_tdata);
                end else begin
                    want = plain_q.pop_front();
                    if (m_tdata !== want) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("ERROR: out_byte expected %02h got %02h", want, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready)
                decrypt_predict(opcode_t'(s_tuser), s_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("zip_stream_decrypt_alternate_top test failed");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_req(input opcode_t op, input logic [7:0] b);
        req_t r;
        r.op  = op;
        r.dat = b;
        pend_q.push_back(r);
        item_cnt++;
    endtask

    task automatic push_session(input int max_data);
        int npw;
        int ndat;
        if ($urandom_range(0, 9) != 0)
            push_req(OP_RESTART, 8'($urandom));
        npw  = $urandom_range(1, 12);
        ndat = $urandom_range(1, max_data);
        for (int i = 0; i < npw; i++)
            push_req(OP_ABSORB, 8'($urandom));
        for (int i = 0; i < ndat; i++) begin
            case ($urandom_range(0, 19))
                0:       push_req(OP_ABSORB, 8'($urandom));
                1:       push_req(opcode_t'($urandom_range(0, 3)), 8'($urandom));
                default: push_req(OP_DECRYPT, 8'($urandom));
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pend_q.size() != 0 || s_tvalid || plain_q.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // data straight from reset keys, both parities, extreme bytes
        push_req(OP_DECRYPT, 8'h00);
        push_req(OP_DECRYPT, 8'hFF);
        push_req(OP_DECRYPT, 8'hFF);
        push_req(OP_DECRYPT, 8'h00);
        // unused opcode is dropped
        push_req(OP_UNUSED,  8'hFF);
        push_req(OP_UNUSED,  8'h00);
        push_req(OP_DECRYPT, 8'h5A);
        // restart at odd parity, then a password
        push_req(OP_RESTART, 8'hFF);
        push_req(OP_ABSORB,  8'h00);
        push_req(OP_ABSORB,  8'hFF);
        push_req(OP_ABSORB,  8'h5A);
        push_req(OP_DECRYPT, 8'hA5);
        // password after data at odd parity
        push_req(OP_ABSORB,  8'h81);
        push_req(OP_DECRYPT, 8'h3C);
        push_req(OP_DECRYPT, 8'hC3);
        // password after data at odd parity, again
        push_req(OP_ABSORB,  8'h7E);
        push_req(OP_DECRYPT, 8'h00);
        push_req(OP_UNUSED,  8'h55);
        push_req(OP_DECRYPT, 8'hFF);
        push_req(OP_RESTART, 8'h00);
        push_req(OP_DECRYPT, 8'h12);
        push_req(OP_DECRYPT, 8'hED);
        wait_drained();

        item_cnt = 0;
        while (item_cnt < RAND_ITEMS / 3) begin
            push_session(40);
            while (pend_q.size() > 40)
                @(negedge aclk);
        end

        // long output stall while requests keep coming
        push_session(30);
        push_session(30);
        rx_hold_req = LONG_HOLD;
        while (pend_q.size() > 0)
            @(negedge aclk);

        // sender pause until everything is back
        wait_drained();

        idle_on = 1'b0;
        while (item_cnt < RAND_ITEMS / 2) begin
            push_session(20);
            while (pend_q.size() > 40)
                @(negedge aclk);
        end

        idle_on = 1'b1;
        while (item_cnt < RAND_ITEMS * 7 / 8) begin
            push_session(40);
            while (pend_q.size() > 40)
                @(negedge aclk);
        end

        idle_on = 1'b0;
        while (item_cnt < RAND_ITEMS) begin
            push_session(40);
            while (pend_q.size() > 40)
                @(negedge aclk);
        end

        wait_drained();
        repeat (20) @(negedge aclk);
        if (err_cnt == 0) begin
            $display("zip_stream_decrypt_alternate_top test passed");
        end else begin
            $display("zip_stream_decrypt_alternate_top test failed");
        end
        $finish;
    end

endmodule
